FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int DefCapacity = 16;

    localparam int KIND_W   = 3;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 3'd0,
        K_INS_END   = 3'd1,
        K_INS_POS   = 3'd2,
        K_DEL_FRONT = 3'd3,
        K_DEL_END   = 3'd4,
        K_DEL_POS   = 3'd5,
        K_SEARCH    = 3'd6,
        K_READOUT   = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // take the accepted beat into the op registers
        logic exec;       // carry out the operation and load its single result
        logic read_step;  // emit head cell, rotate the list by one
    } ple_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic read_go;    // read-out of a non-empty list
        logic read_last;  // current read step delivers the final entry
    } ple_sts_t;

endpackage

FILE: design/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed 32-bit keys with positional insert/delete,
// search and full read-out.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells; inserts, deletes and searches
// touch every cell in parallel, so a non-read-out operation takes the beat,
// then executes and loads the result register once the output register is free.
// Read-out takes the beat, decodes, then emits one entry per read step: the
// chain rotates one cell per beat towards the head, so entries leave back to
// back while m_tready is high, and the list is back in order once the last
// beat (tlast high) is issued. Status in m_tuser is 0 ok, 1 bad position, 2
// list full, 3 list empty. One item is in flight at a time; the next beat is
// taken once the previous item's results are all queued in the output
// register, and m_tready holding a full output register back delays it.
// ----------------------------------------------------------------------------
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key [31:0], position [36:32], zero pad
    input  logic [2:0]  s_tuser,   // kind [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // found [0], key_out [32:1], count [37:33], pad
    output logic [1:0]  m_tuser,   // status [1:0]
    output logic        m_tlast
);

    ple_cmd_t                cmd;
    ple_sts_t                sts;
    logic [STATUS_W-1:0]     status;
    logic                    found;
    logic signed [KEY_W-1:0] key_out;
    logic [COUNT_W-1:0]      count;

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (s_tuser),
        .in_key      (s_tdata[31:0]),
        .in_position (s_tdata[36:32]),
        .out_status  (status),
        .out_found   (found),
        .out_key     (key_out),
        .out_count   (count),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'b00, count, key_out, found};
    assign m_tuser = status;

endmodule

FILE: design/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer: accepts a beat, runs the operation, steps through read-out.
// ----------------------------------------------------------------------------
module ple_ctrl
    import ple_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  ple_sts_t sts,
    output ple_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.read_go) begin
                    state_next = S_READ;
                end else if (slot_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                if (slot_free) begin
                    cmd.read_step = 1'b1;
                    if (sts.read_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec || cmd.read_step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: design/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// Cell chain holding the list, op registers, count and result register.
// ----------------------------------------------------------------------------
module ple_datapath
    import ple_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ple_cmd_t                   cmd,
    output ple_sts_t                   sts,
    input  logic [KIND_W-1:0]          in_kind,
    input  logic signed [KEY_W-1:0]    in_key,
    input  logic [POS_W-1:0]           in_position,
    output logic [STATUS_W-1:0]        out_status,
    output logic                       out_found,
    output logic signed [KEY_W-1:0]    out_key,
    output logic [COUNT_W-1:0]         out_count,
    output logic                       out_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RD_W  = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic [KIND_W-1:0]       kind_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [RD_W-1:0]         rd_reg, rd_next;
    logic [KEY_W-1:0]        cell_reg  [CAPACITY];
    logic [KEY_W-1:0]        cell_next [CAPACITY];
    logic [CAPACITY-1:0]     hit;

    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    found_reg, found_next;
    logic [KEY_W-1:0]        key_out_reg, key_out_next;
    logic [COUNT_W-1:0]      cnt_out_reg, cnt_out_next;
    logic                    last_reg, last_next;

    logic [CMP_W-1:0]        cnt_ext, pos_ext, rd_ext, idx;
    logic                    full, empty, do_ins, do_del, found_c;
    status_t                 status_c;
    logic [CNT_W+COUNT_W-1:0] cnt_wide;

    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(pos_reg);
    assign rd_ext  = CMP_W'(rd_reg);
    assign full    = (cnt_ext == CMP_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // parallel key compare over live cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_hit
            assign hit[g] = (CMP_W'(g) < cnt_ext) && (cell_reg[g] == key_reg);
        end
    endgenerate
    assign found_c = |hit;

    always_comb begin
        status_c = ST_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        idx      = '0;
        case (kind_reg)
            K_INS_FRONT, K_INS_END, K_INS_POS: begin
                if (full) begin
                    status_c = ST_FULL;
                end else if (kind_reg == K_INS_FRONT) begin
                    do_ins = 1'b1;
                end else if (kind_reg == K_INS_END) begin
                    do_ins = 1'b1;
                    idx    = cnt_ext;
                end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                    status_c = ST_BAD_POS;
                end else begin
                    do_ins = 1'b1;
                    idx    = pos_ext - CMP_W'(1);
                end
            end
            K_DEL_FRONT, K_DEL_END, K_DEL_POS: begin
                if (empty) begin
                    status_c = ST_EMPTY;
                end else if (kind_reg == K_DEL_FRONT) begin
                    do_del = 1'b1;
                end else if (kind_reg == K_DEL_END) begin
                    do_del = 1'b1;
                    idx    = cnt_ext - CMP_W'(1);
                end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    status_c = ST_BAD_POS;
                end else begin
                    do_del = 1'b1;
                    idx    = pos_ext - CMP_W'(1);
                end
            end
            default: ;
        endcase
    end

    // per-cell next value: shift right for insert, left for delete,
    // rotate towards the head during read-out
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            always_comb begin
                cell_next[g] = cell_reg[g];
                if (cmd.exec && do_ins) begin
                    if (CMP_W'(g) == idx) begin
                        cell_next[g] = key_reg;
                    end else if (CMP_W'(g) > idx) begin
                        if (g > 0) begin
                            cell_next[g] = cell_reg[(g > 0) ? g - 1 : 0];
                        end
                    end
                end else if (cmd.exec && do_del) begin
                    if (CMP_W'(g) >= idx && g < CAPACITY - 1) begin
                        cell_next[g] = cell_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    end
                end else if (cmd.read_step) begin
                    if (CMP_W'(g) == cnt_ext - CMP_W'(1)) begin
                        cell_next[g] = cell_reg[0];
                    end else if (CMP_W'(g) < cnt_ext - CMP_W'(1) && g < CAPACITY - 1) begin
                        cell_next[g] = cell_reg[(g < CAPACITY - 1) ? g + 1 : g];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.exec && do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.exec && do_del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        rd_next = rd_reg;
        if (cmd.latch) begin
            rd_next = '0;
        end else if (cmd.read_step && !sts.read_last) begin
            rd_next = rd_reg + RD_W'(1);
        end
    end

    assign sts.read_go   = (kind_reg == K_READOUT) && !empty;
    assign sts.read_last = (rd_ext == cnt_ext - CMP_W'(1));

    assign cnt_wide = {{COUNT_W{1'b0}}, count_next};

    always_comb begin
        status_next  = status_reg;
        found_next   = found_reg;
        key_out_next = key_out_reg;
        cnt_out_next = cnt_out_reg;
        last_next    = last_reg;
        if (cmd.exec) begin
            status_next  = status_c;
            found_next   = (kind_reg == K_SEARCH) && found_c;
            key_out_next = '0;
            cnt_out_next = cnt_wide[COUNT_W-1:0];
            last_next    = 1'b1;
        end else if (cmd.read_step) begin
            status_next  = ST_OK;
            found_next   = 1'b0;
            key_out_next = cell_reg[0];
            cnt_out_next = cnt_wide[COUNT_W-1:0];
            last_next    = sts.read_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg <= in_kind;
            key_reg  <= in_key;
            pos_reg  <= in_position;
        end
        rd_reg      <= rd_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        key_out_reg <= key_out_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
        for (int i = 0; i < CAPACITY; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_key    = key_out_reg;
    assign out_count  = cnt_out_reg;
    assign out_last   = last_reg;

endmodule

FILE: verif/tb_positional_list_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_top
// Self-checking bench for the positional list engine.
// ----------------------------------------------------------------------------
// A shadow list, kept as a queue, is updated for every input beat that is
// taken. The expected result beats go into a queue. A checker pops one entry
// for each result beat and compares it field by field. Stimulus covers the
// empty list, edge keys and positions, a full list, and a random walk that
// fills and drains the list. Both sides stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_top;
    import ple_pkg::*;

    localparam int LIST_CAP    = DefCapacity;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        status_t            status;
        logic               found;
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] count;
        logic               last;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // key [31:0], position [36:32], zero pad
    logic [2:0]  s_tuser  = K_INS_FRONT;   // kind [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // found [0], key_out [32:1], count [37:33], pad
    logic [1:0]  m_tuser;         // status [1:0]
    logic        m_tlast;

    logic [KEY_W-1:0] shadow_keys[$];
    list_result_t     pending_results[$];
    list_result_t     want_res;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned readouts = 0;
    int unsigned search_hits = 0;
    int unsigned flagged[4] = '{0, 0, 0, 0};
    int unsigned stall_cycles = 0;
    bit          list_growing = 1'b1;

    positional_list_engine_top #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Apply one operation to the shadow list and queue its result beats.
    function automatic void list_apply_op(kind_t k, logic [KEY_W-1:0] key,
                                          logic [POS_W-1:0] pos);
        status_t      st;
        logic         hit;
        int           idx;
        int           len;
        list_result_t r;
        st  = ST_OK;
        hit = 1'b0;
        idx = -1;
        len = shadow_keys.size();
        case (k)
            K_INS_FRONT, K_INS_END, K_INS_POS: begin
                if (len >= LIST_CAP) begin
                    st = ST_FULL;
                end else if (k == K_INS_FRONT) begin
                    idx = 0;
                end else if (k == K_INS_END) begin
                    idx = len;
                end else if (int'(pos) < 1 || int'(pos) > len + 1) begin
                    st = ST_BAD_POS;
                end else begin
                    idx = int'(pos) - 1;
                end
                if (idx >= 0)
                    shadow_keys.insert(idx, key);
            end
            K_DEL_FRONT, K_DEL_END, K_DEL_POS: begin
                if (len == 0) begin
                    st = ST_EMPTY;
                end else if (k == K_DEL_FRONT) begin
                    idx = 0;
                end else if (k == K_DEL_END) begin
                    idx = len - 1;
                end else if (int'(pos) < 1 || int'(pos) > len) begin
                    st = ST_BAD_POS;
                end else begin
                    idx = int'(pos) - 1;
                end
                if (idx >= 0)
                    shadow_keys.delete(idx);
            end
            K_SEARCH: begin
                foreach (shadow_keys[i])
                    if (shadow_keys[i] == key)
                        hit = 1'b1;
                if (hit)
                    search_hits++;
            end
            default: begin
                readouts++;
                if (len != 0) begin
                    foreach (shadow_keys[i]) begin
                        r.status  = ST_OK;
                        r.found   = 1'b0;
                        r.key_out = shadow_keys[i];
                        r.count   = COUNT_W'(len);
                        r.last    = (i == len - 1);
                        pending_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        flagged[st]++;
        r.status  = st;
        r.found   = hit;
        r.key_out = '0;
        r.count   = COUNT_W'(shadow_keys.size());
        r.last    = 1'b1;
        pending_results.push_back(r);
    endfunction

    // Valid is left high after a beat is taken; it only drops for a gap.
    task automatic send_item(kind_t k, logic [KEY_W-1:0] key, logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct && gap < 12)
            gap++;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {3'b000, pos, key};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        list_apply_op(k, key, pos);
        items_sent++;
    endtask

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got,
                                   logic [KEY_W-1:0] want);
        $display("%0t ns: result beat %0d: %s: got %h, want %h",
                 $time, beats_seen, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing expected", m_tdata[32:1], '0);
            end else begin
                want_res = pending_results.pop_front();
                if (m_tuser !== want_res.status)
                    report_mismatch("status", m_tuser, want_res.status);
                if (m_tdata[0] !== want_res.found)
                    report_mismatch("found", m_tdata[0], want_res.found);
                if (m_tdata[32:1] !== want_res.key_out)
                    report_mismatch("key_out", m_tdata[32:1], want_res.key_out);
                if (m_tdata[37:33] !== want_res.count)
                    report_mismatch("count", m_tdata[37:33], want_res.count);
                if (m_tlast !== want_res.last)
                    report_mismatch("tlast", m_tlast, want_res.last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_empty_list();
        send_item(K_READOUT, 32'h0000_0000, 5'd0);
        send_item(K_SEARCH, 32'h0000_0000, 5'd0);
        send_item(K_DEL_FRONT, 32'h0000_0000, 5'd1);
        send_item(K_DEL_END, 32'hFFFF_FFFF, 5'd1);
        send_item(K_DEL_POS, 32'h0000_0000, 5'd0);
        send_item(K_DEL_POS, 32'hFFFF_FFFF, 5'd31);
    endtask

    task automatic test_edge_positions();
        send_item(K_INS_POS, 32'h1234_5678, 5'd0);
        send_item(K_INS_POS, 32'h1234_5678, 5'd2);
        send_item(K_INS_POS, 32'h8000_0000, 5'd1);   // first entry via position
        send_item(K_INS_FRONT, 32'h7FFF_FFFF, 5'd0);
        send_item(K_INS_END, 32'hFFFF_FFFF, 5'd31);
        send_item(K_INS_END, 32'h0000_0000, 5'd0);
        send_item(K_INS_POS, 32'h5555_5555, 5'd3);
        send_item(K_INS_POS, 32'hAAAA_AAAA, 5'd6);   // one past the tail
        send_item(K_INS_POS, 32'h0000_0001, 5'd8);
        send_item(K_INS_POS, 32'h0000_0001, 5'd31);
        send_item(K_SEARCH, 32'h8000_0000, 5'd0);
        send_item(K_SEARCH, 32'h0000_0001, 5'd0);
        send_item(K_READOUT, 32'h0000_0000, 5'd0);
        send_item(K_DEL_POS, 32'h0000_0000, 5'd0);
        send_item(K_DEL_POS, 32'h0000_0000, 5'd7);
        send_item(K_DEL_POS, 32'h0000_0000, 5'd3);
        send_item(K_DEL_FRONT, 32'h0000_0000, 5'd0);
        send_item(K_DEL_END, 32'h0000_0000, 5'd0);
        send_item(K_READOUT, 32'h0000_0000, 5'd0);
    endtask

    task automatic test_full_list();
        kind_t k;
        while (shadow_keys.size() < LIST_CAP) begin
            k = kind_t'($urandom_range(K_INS_FRONT, K_INS_POS));
            send_item(k, $urandom(), POS_W'($urandom_range(1, shadow_keys.size() + 1)));
        end
        // full check wins over the position check
        send_item(K_INS_FRONT, $urandom(), 5'd0);
        send_item(K_INS_END, $urandom(), 5'd0);
        send_item(K_INS_POS, $urandom(), 5'd0);
        send_item(K_INS_POS, $urandom(), 5'd5);
        send_item(K_SEARCH, shadow_keys[LIST_CAP-1], 5'd0);
        send_item(K_READOUT, 32'h0000_0000, 5'd0);
        while (shadow_keys.size() != 0) begin
            k = kind_t'($urandom_range(K_DEL_FRONT, K_DEL_POS));
            send_item(k, $urandom(), POS_W'($urandom_range(1, shadow_keys.size())));
        end
        send_item(K_DEL_POS, 32'h0000_0000, 5'd1);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 32'h8000_0000;
        else if (sel < 20)
            return 32'h7FFF_FFFF;
        else if (sel < 25)
            return 32'hFFFF_FFFF;
        else if (sel < 45)
            return KEY_W'($urandom_range(0, 7));   // small pool, makes repeats
        return $urandom();
    endfunction

    // Random walk that swings between filling and draining the list.
    task automatic test_random_ops(int unsigned n_items);
        int unsigned      sel;
        int unsigned      len;
        kind_t            k;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        repeat (n_items) begin
            len = shadow_keys.size();
            if (len == LIST_CAP)
                list_growing = 1'b0;
            else if (len == 0)
                list_growing = 1'b1;
            sel = $urandom_range(0, 99);
            key = pick_key();
            pos = POS_W'($urandom_range(0, 31));
            if (sel < 7) begin
                k = K_READOUT;
            end else if (sel < 20) begin
                k = K_SEARCH;
                if (len != 0 && $urandom_range(0, 1))
                    key = shadow_keys[$urandom_range(0, len - 1)];
            end else if ((sel < 65) == list_growing) begin
                k = kind_t'($urandom_range(K_INS_FRONT, K_INS_POS));
                if ($urandom_range(0, 99) < 85)
                    pos = POS_W'($urandom_range(1, len + 1));
            end else begin
                k = kind_t'($urandom_range(K_DEL_FRONT, K_DEL_POS));
                if (len != 0 && $urandom_range(0, 99) < 85)
                    pos = POS_W'($urandom_range(1, len));
            end
            send_item(k, key, pos);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 79;
        test_empty_list();
        test_edge_positions();
        test_full_list();
        test_random_ops(50);

        tx_idle_pct = 79;
        rx_idle_pct = 8;
        test_random_ops(50);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_full_list();
        test_random_ops(50);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Ran %0d items, %0d result beats, %0d read-outs, %0d search hits",
                 items_sent, beats_seen, readouts, search_hits);
        $display("Flags seen: %0d bad position, %0d full list, %0d empty list",
                 flagged[ST_BAD_POS], flagged[ST_FULL], flagged[ST_EMPTY]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
